// File: hdl/hrc_pkg.sv
// shared types and constants for the handle table with reference counts
`timescale 1ns / 1ps
`default_nettype none

package hrc_pkg;

   // fixed field widths of the stream beats
   localparam int FUNC_W     = 3;
   localparam int HANDLE_W   = 10;
   localparam int KIND_W     = 4;
   localparam int TAG_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // defaults for the top level parameters
   localparam int DEF_TABLE_DEPTH   = 1024;
   localparam int DEF_COUNT_WIDTH   = 16;
   localparam int DEF_CONTEXT_WIDTH = 32;

   // kinds 0..9 are real objects, 10 marks no object
   localparam logic [KIND_W-1:0] KIND_LIMIT = 4'd10;
   localparam logic [KIND_W-1:0] KIND_NONE  = 4'd10;

   typedef enum logic [FUNC_W-1:0] {
      FN_CREATE  = 3'd0,
      FN_DESTROY = 3'd1,
      FN_REF     = 3'd2,
      FN_DEREF   = 3'd3,
      FN_QUERY   = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_INVALID    = 3'd1,
      STAT_REFERENCED = 3'd2,
      STAT_ZERO       = 3'd3,
      STAT_FULL       = 3'd4,
      STAT_BADTYPE    = 3'd5,
      STAT_SATURATED  = 3'd6
   } status_type;

   typedef enum logic {
      CNT_INC = 1'b0,
      CNT_DEC = 1'b1
   } cnt_op_type;

   // compare results of the count unit
   typedef struct packed {
      logic is_zero;
      logic le_one;
      logic is_max;
   } cnt_flags_type;

endpackage

`default_nettype wire

// File: hdl/hrc_entry_ram.sv
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hrc_entry_ram import hrc_pkg::*; #(
   parameter int DEPTH  = DEF_TABLE_DEPTH,
   parameter int DATA_W = 1 + KIND_W + DEF_COUNT_WIDTH + DEF_CONTEXT_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/hrc_count_alu.sv
// shared count unit: increment or decrement plus range compares
`timescale 1ns / 1ps
`default_nettype none

module hrc_count_alu import hrc_pkg::*; #(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic [COUNT_WIDTH-1:0] count_in,
   input  cnt_op_type             op,
   output logic [COUNT_WIDTH-1:0] count_out,
   output cnt_flags_type          flags
);

   always_comb begin
      flags.is_zero = (count_in == '0);
      flags.le_one  = (count_in <= COUNT_WIDTH'(1));
      flags.is_max  = &count_in;
      if (op == CNT_INC) begin
         count_out = count_in + COUNT_WIDTH'(1);
      end else begin
         count_out = count_in - COUNT_WIDTH'(1);
      end
   end

endmodule

`default_nettype wire

// File: hdl/handle_table_refcount_unit.sv
// top level: handle table with reference counts, sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

// a request beat is accepted in idle; the execute state then finishes it from the entry
//   read back; a create once fresh handles are used up first probes slots from 1 (up to
//   depth-1) in the scan state, reading one entry per cycle; no new request is accepted
//   until the result is loaded, as one entry is read then written through the single memory
// reset: synchronous, clears the sequencer, the result valid flag and the fresh handle
//   counter (back to 1); no clearing pass, slots at or above the counter count as unused

module handle_table_refcount_unit import hrc_pkg::*; #(
   parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
   parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH,
   parameter int CONTEXT_WIDTH = DEF_CONTEXT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // handle[9:0], obj_kind[13:10], context_tag[45:14]
   input  logic [FUNC_W-1:0]     req_tuser,  // func[2:0]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // handle_out[9:0], kind_out[13:10], context_out[45:14]
   output logic [STATUS_W-1:0]   rsp_tuser   // status[2:0]
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int FRESH_W = IDX_W + 1;
   localparam int CMP_W   = (FRESH_W > HANDLE_W) ? FRESH_W : HANDLE_W;
   localparam int DATA_W  = 1 + KIND_W + COUNT_WIDTH + CONTEXT_WIDTH;

   // one-hot sequencer states
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   // request beat fields
   logic [HANDLE_W-1:0] req_handle;
   logic [KIND_W-1:0]   req_kind;
   logic [TAG_W-1:0]    req_tag;
   logic                req_accept;

   assign req_handle = req_tdata[HANDLE_W-1:0];
   assign req_kind   = req_tdata[HANDLE_W +: KIND_W];
   assign req_tag    = req_tdata[HANDLE_W+KIND_W +: TAG_W];

   // sequencer and latched request
   state_type                state_ff, state_in;
   logic [FUNC_W-1:0]        func_ff, func_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [CONTEXT_WIDTH-1:0] ctx_ff, ctx_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     hvalid_ff, hvalid_in;
   logic [IDX_W-1:0]         probe_ff, probe_in;
   logic [FRESH_W-1:0]       fresh_ff, fresh_in;
   logic                     fresh_full;

   // result register
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]         rsp_ctx_ff, rsp_ctx_in;

   // memory port
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [IDX_W-1:0]         rd_addr;
   logic [DATA_W-1:0]        rd_data;

   // entry read back, layout {used, kind, count, context}
   logic                     rd_used;
   logic [KIND_W-1:0]        rd_kind;
   logic [COUNT_WIDTH-1:0]   rd_count;
   logic [CONTEXT_WIDTH-1:0] rd_ctx;

   // count unit
   cnt_op_type               cnt_op;
   logic [COUNT_WIDTH-1:0]   cnt_next;
   cnt_flags_type            cnt_flags;

   // finishing control
   logic                     out_free;
   logic                     finish;
   status_type               res_status;
   logic [HANDLE_W-1:0]      res_handle;
   logic [KIND_W-1:0]        res_kind;
   logic [TAG_W-1:0]         res_ctx;
   logic                     entry_ok;

   assign rd_used  = rd_data[DATA_W-1];
   assign rd_kind  = rd_data[COUNT_WIDTH+CONTEXT_WIDTH +: KIND_W];
   assign rd_count = rd_data[CONTEXT_WIDTH +: COUNT_WIDTH];
   assign rd_ctx   = rd_data[CONTEXT_WIDTH-1:0];

   assign fresh_full = (fresh_ff == FRESH_W'(TABLE_DEPTH));
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   // a result may retire when the output register is empty or being drained
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   // slots at or above the fresh counter count as unused through hvalid_ff, whatever they hold
   assign entry_ok   = hvalid_ff && rd_used;
   assign cnt_op     = (func_ff == FN_REF) ? CNT_INC : CNT_DEC;

   hrc_entry_ram #(
      .DEPTH  (TABLE_DEPTH),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hrc_count_alu #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_alu (
      .count_in  (rd_count),
      .op        (cnt_op),
      .count_out (cnt_next),
      .flags     (cnt_flags)
   );

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      kind_in    = kind_ff;
      ctx_in     = ctx_ff;
      idx_in     = idx_ff;
      hvalid_in  = hvalid_ff;
      probe_in   = probe_ff;
      fresh_in   = fresh_ff;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = rd_data;
      finish     = 1'b0;
      res_status = STAT_OK;
      res_handle = '0;
      res_kind   = '0;
      res_ctx    = '0;

      case (state_ff)
         S_IDLE: begin
            // creates start the probe at slot 1, everything else reads its target
            if (req_tuser == FN_CREATE) begin
               rd_addr = IDX_W'(1);
            end else begin
               rd_addr = IDX_W'(req_handle);
            end
            if (req_accept) begin
               func_in   = req_tuser;
               kind_in   = req_kind;
               ctx_in    = CONTEXT_WIDTH'(req_tag);
               idx_in    = IDX_W'(req_handle);
               hvalid_in = (req_handle != '0) && (CMP_W'(req_handle) < CMP_W'(fresh_ff));
               probe_in  = IDX_W'(1);
               if ((req_tuser == FN_CREATE) && (req_kind < KIND_LIMIT) && fresh_full) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            finish = 1'b1;
            case (func_ff)
               FN_CREATE: begin
                  if (kind_ff >= KIND_LIMIT) begin
                     res_status = STAT_BADTYPE;
                  end else begin
                     // fresh handle still available here
                     wr_en      = out_free;
                     wr_addr    = fresh_ff[IDX_W-1:0];
                     wr_data    = {1'b1, kind_ff, COUNT_WIDTH'(1), ctx_ff};
                     res_handle = HANDLE_W'(fresh_ff[IDX_W-1:0]);
                     if (out_free) begin
                        fresh_in = fresh_ff + FRESH_W'(1);
                     end
                  end
               end
               FN_DESTROY: begin
                  if (!entry_ok) begin
                     res_status = STAT_INVALID;
                  end else if (!cnt_flags.le_one) begin
                     res_status = STAT_REFERENCED;
                  end else begin
                     wr_en   = out_free;
                     wr_data = {1'b0, rd_kind, rd_count, rd_ctx};
                  end
               end
               FN_REF: begin
                  if (!entry_ok) begin
                     res_status = STAT_INVALID;
                  end else if (cnt_flags.is_max) begin
                     res_status = STAT_SATURATED;
                  end else begin
                     wr_en   = out_free;
                     wr_data = {1'b1, rd_kind, cnt_next, rd_ctx};
                  end
               end
               FN_DEREF: begin
                  if (!entry_ok) begin
                     res_status = STAT_INVALID;
                  end else if (cnt_flags.is_zero) begin
                     res_status = STAT_ZERO;
                  end else begin
                     // dropping the last reference frees the slot
                     wr_en   = out_free;
                     wr_data = {!cnt_flags.le_one, rd_kind, cnt_next, rd_ctx};
                  end
               end
               FN_QUERY: begin
                  if (!entry_ok) begin
                     res_status = STAT_INVALID;
                     res_kind   = KIND_NONE;
                  end else begin
                     res_kind = rd_kind;
                     res_ctx  = TAG_W'(rd_ctx);
                  end
               end
               default: begin
                  // unknown function: no change, all-zero result
                  res_status = STAT_OK;
               end
            endcase
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         S_SCAN: begin
            // rd_data holds the slot at probe_ff, one slot per cycle
            rd_addr = probe_ff;
            if (!rd_used) begin
               finish     = 1'b1;
               wr_en      = out_free;
               wr_addr    = probe_ff;
               wr_data    = {1'b1, kind_ff, COUNT_WIDTH'(1), ctx_ff};
               res_handle = HANDLE_W'(probe_ff);
            end else if (probe_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               finish     = 1'b1;
               res_status = STAT_FULL;
            end else begin
               probe_in = probe_ff + IDX_W'(1);
               rd_addr  = probe_ff + IDX_W'(1);
            end
            if (finish && out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ctx_in    = rsp_ctx_ff;
      if (finish && out_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_status_in = res_status;
         rsp_handle_in = res_handle;
         rsp_kind_in   = res_kind;
         rsp_ctx_in    = res_ctx;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fresh_ff      <= FRESH_W'(1);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fresh_ff      <= fresh_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      kind_ff       <= kind_in;
      ctx_ff        <= ctx_in;
      idx_ff        <= idx_in;
      hvalid_ff     <= hvalid_in;
      probe_ff      <= probe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_ctx_ff    <= rsp_ctx_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - HANDLE_W - KIND_W - TAG_W)'(0),
                        rsp_ctx_ff, rsp_kind_ff, rsp_handle_ff};

`ifndef SYNTHESIS
   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff != '0) && (fresh_ff <= FRESH_W'(TABLE_DEPTH)))
      else $error("fresh handle counter out of range");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EXEC) || (state_ff == S_SCAN))
      else $error("accepted request did not start work");

   a_no_slot_zero_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != '0))
      else $error("entry write to reserved slot zero");

   a_scan_when_exhausted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> fresh_full)
      else $error("free-slot probe while fresh handles remain");

   a_full_gives_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_status_ff == STAT_FULL)) |-> (rsp_handle_ff == '0))
      else $error("table full result carries a handle");
`endif

endmodule

`default_nettype wire
